@@ rtl/lvg_pkg.sv @@
// Package: shared types and constants for the loss value and gradient block.
package lvg_pkg;
  localparam logic [1:0] MODE_MAE = 2'd0;
  localparam logic [1:0] MODE_MSE = 2'd1;
  localparam logic [1:0] MODE_CE  = 2'd2;
  localparam logic [1:0] ADDR_LOSS_MODE = 2'd0;
  localparam int ACC_W = 48;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOG, ST_DIV, ST_MUL, ST_DONE
  } be_state_t;
endpackage

@@ rtl/lvg_if.sv @@
// Interfaces: input item channel and result item channel.
interface lvg_in_if #(parameter int DW = 32);
  logic valid;
  logic ready;
  logic signed [DW-1:0] predicted;
  logic signed [DW-1:0] expected;
  logic last_element;
  modport source (output valid, predicted, expected, last_element, input ready);
  modport sink (input valid, predicted, expected, last_element, output ready);
endinterface

interface lvg_out_if #(parameter int DW = 32);
  logic valid;
  logic ready;
  logic signed [DW-1:0] gradient;
  logic signed [47:0] loss_sum;
  logic loss_valid;
  modport source (output valid, gradient, loss_sum, loss_valid, input ready);
  modport sink (input valid, gradient, loss_sum, loss_valid, output ready);
endinterface

@@ rtl/lvg_front.sv @@
// Front end: accepts items, tags them with mode, queues them (depth 2).
module lvg_front import lvg_pkg::*; #(
  parameter int DW = 32
) (
  input  logic clk,
  input  logic rst,
  lvg_in_if.sink in_ch,
  input  logic [1:0] mode,
  output logic q_valid,
  input  logic q_ready,
  output logic signed [DW-1:0] q_p,
  output logic signed [DW-1:0] q_t,
  output logic q_last,
  output logic [1:0] q_mode
);
  logic [2*DW+2:0] slot [2];
  logic rd, wr;
  logic [1:0] cnt;
  logic [1:0] cnt_next;
  logic push, pop;

  assign in_ch.ready = (cnt != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign pop = q_valid && q_ready;
  assign q_valid = (cnt != 2'd0);
  assign {q_mode, q_last, q_p, q_t} = slot[rd];
  assign cnt_next = cnt + {1'b0, push} - {1'b0, pop};

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      rd <= 1'b0;
      wr <= 1'b0;
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
      if (push) wr <= ~wr;
      if (pop) rd <= ~rd;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) slot[wr] <= {mode, in_ch.last_element, in_ch.predicted, in_ch.expected};
  end

`ifndef SYNTH
  a_no_over: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("queue count overflow");
  a_full: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2 && !pop) |=> cnt == 2'd2) else $error("full queue lost item");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> cnt == $past(cnt) + 2'd1) else $error("count slip");
`endif
endmodule

@@ rtl/lvg_back.sv @@
// Back end: computes gradient and loss term, accumulates, holds result.
module lvg_back import lvg_pkg::*; #(
  parameter int DW = 32,
  parameter int FB = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_ready,
  input  logic signed [DW-1:0] q_p,
  input  logic signed [DW-1:0] q_t,
  input  logic q_last,
  input  logic [1:0] q_mode,
  lvg_out_if.source out_ch
);
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam int EW = $clog2(DW + 1);
  localparam int PW = 2 * (DW + 1);

  be_state_t state, state_next;
  logic [6:0] cyc;
  logic signed [DW-1:0] tt;
  logic lst;
  logic [1:0] md;
  logic [DW:0] a;          // argument p+eps, >= 1
  logic [EW-1:0] ex;
  logic [31:0] m;
  logic [31:0] f;
  logic [DW-1:0] rem;
  logic [DW+FB-1:0] quo;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] term;
  logic signed [DW-1:0] grad;
  logic [DW:0] ma, mb;
  logic lneg;
  logic [ACC_W-1:0] lmag;

  // datapath nets
  logic signed [DW:0] d_w;
  logic [DW:0] dmag;
  logic [DW:0] tmag;
  logic [EW-1:0] ex_w;
  logic [63:0] sq;
  logic [31:0] sq_m;
  logic sq_hi;
  logic signed [31:0] l24;
  logic signed [63:0] lp;
  logic [63:0] lpm;
  logic [DW:0] rem_sh;
  logic rem_ge;
  logic [PW-1:0] prod;
  logic [PW-1:0] prod_r;
  logic [PW-1:0] prod_s;
  logic [ACC_W-1:0] mres;
  logic signed [ACC_W:0] sum;
  logic signed [DW+1:0] g2;
  logic [DW:0] qlim;

  assign d_w = q_p - q_t;
  assign dmag = d_w[DW] ? -d_w : d_w;
  assign tmag = tt[DW-1] ? -{tt[DW-1], tt} : {tt[DW-1], tt};
  assign sq = {32'd0, m} * {32'd0, m};
  assign sq_hi = sq[61];
  assign sq_m = sq_hi ? sq[61:30] >> 1 : sq[61:30];
  assign l24 = ($signed(32'(ex)) - 32'(FB)) * 32'sd16777216 + $signed({8'd0, f[31:8]});
  assign lp = l24 * $signed({1'b0, LN2_Q32});
  assign lpm = lp[63] ? -lp : lp;
  assign rem_sh = {rem, quo[DW+FB-1]};
  assign rem_ge = rem_sh >= a;
  assign prod = ma * mb;
  assign prod_r = prod + (PW'(1) << (FB - 1));
  assign prod_s = prod_r >> FB;
  assign mres = (prod_s > PW'(ACC_MAX)) ? ACC_MAX : ACC_W'(prod_s);
  assign g2 = {d_w, 1'b0};
  assign qlim = (tt > 0) ? (DW+1)'(1) << (DW-1) : ((DW+1)'(1) << (DW-1)) - 1;
  assign sum = {acc[ACC_W-1], acc} + {term[ACC_W-1], term};
  assign q_ready = (state == ST_IDLE) && !out_ch.valid;

  // leading one of the log argument
  always_comb begin
    ex_w = '0;
    for (int i = 0; i <= DW; i++) if (a[i]) ex_w = EW'(i);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (q_valid && q_ready) state_next = (q_mode == MODE_CE) ? ST_LOG :
                                                   (q_mode == MODE_MSE) ? ST_MUL : ST_DONE;
      ST_LOG:  if (cyc == 7'd33) state_next = ST_DIV;
      ST_DIV:  if (cyc == 7'(DW + FB - 1)) state_next = ST_MUL;
      ST_MUL:  state_next = ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // output gradient
  always_comb begin
    out_ch.gradient = grad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      acc <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DONE) begin
        out_ch.valid <= 1'b1;
        out_ch.loss_valid <= lst;
        if (!lst) out_ch.loss_sum <= '0;
        else if (sum > $signed({ACC_MAX[ACC_W-1], ACC_MAX})) out_ch.loss_sum <= ACC_MAX;
        else if (sum < $signed({ACC_MIN[ACC_W-1], ACC_MIN})) out_ch.loss_sum <= ACC_MIN;
        else out_ch.loss_sum <= sum[ACC_W-1:0];
        if (lst) acc <= '0;
        else if (sum > $signed({ACC_MAX[ACC_W-1], ACC_MAX})) acc <= ACC_MAX;
        else if (sum < $signed({ACC_MIN[ACC_W-1], ACC_MIN})) acc <= ACC_MIN;
        else acc <= sum[ACC_W-1:0];
      end else if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  // datapath sequencing
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (q_valid && q_ready) begin
        tt <= q_t; lst <= q_last; md <= q_mode; cyc <= '0; f <= '0;
        ma <= dmag;
        mb <= dmag;
        a <= q_p[DW-1] ? (DW+1)'(1) : (DW+1)'(q_p) + 1'b1;
        if (q_mode == MODE_MAE) begin
          grad <= (d_w > 0) ? DW'(1) << FB : -(DW'(1) << FB);
          term <= ACC_W'(dmag);
        end else if (q_mode == MODE_MSE) begin
          grad <= (g2 > $signed({2'b0, {(DW-1){1'b1}}})) ? {1'b0, {(DW-1){1'b1}}} :
                  (g2 < -$signed({2'b0, {(DW-1){1'b1}}}) - 1) ? {1'b1, {(DW-1){1'b0}}} :
                  g2[DW-1:0];
          term <= '0;
        end else begin
          grad <= '0;
          term <= '0;
        end
      end
      ST_LOG: begin
        cyc <= (cyc == 7'd33) ? '0 : cyc + 7'd1;
        if (cyc == 7'd0) begin
          // exponent
          ex <= ex_w;
        end else if (cyc == 7'd1) begin
          // mantissa normalize to [2^30, 2^31)
          m <= (ex >= EW'(30)) ? 32'(a >> (ex - EW'(30))) : 32'(a << (EW'(30) - ex));
        end else begin
          // 32 squaring steps, one fraction bit each
          m <= sq_m;
          f <= {f[30:0], sq_hi};
        end
        if (cyc == 7'd33) begin
          rem <= '0;
          quo <= {tmag[DW-1:0], {FB{1'b0}}};
        end
      end
      ST_DIV: begin
        // restoring divider, one quotient bit per cycle
        cyc <= cyc + 7'd1;
        rem <= rem_ge ? DW'(rem_sh - a) : rem_sh[DW-1:0];
        quo <= {quo[DW+FB-2:0], rem_ge};
        if (cyc == 7'd0) begin
          // log term magnitude and sign
          lneg <= lp[63];
          lmag <= ACC_W'((lpm + (64'd1 << (55 - FB))) >> (56 - FB));
          ma <= tmag;
        end
        if (cyc == 7'd1) mb <= (DW+1)'(lmag);
      end
      ST_MUL: begin
        if (md == MODE_CE) begin
          if (quo > (DW+FB)'(qlim)) grad <= (tt > 0) ? -DW'(qlim) : DW'(qlim);
          else grad <= (tt > 0) ? -quo[DW-1:0] : quo[DW-1:0];
          term <= ((tt < 0) == lneg) ? -$signed(mres) : $signed(mres);
        end else begin
          term <= $signed(mres);
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !q_ready) else $error("accept while busy");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid) else $error("result dropped");
  a_clr: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && lst) |=> acc == '0) else $error("accumulator not cleared");
`endif
endmodule

@@ rtl/loss_value_and_gradient.sv @@
// Top level: loss value and gradient unit with APB mode register.
// One result item per input item. The back end takes one item at a time and
// waits for its result to be taken before the next. MAE items go straight to
// the done state and MSE items pass through the multiply state; cross-entropy
// items also run the squaring log loop and the bit-serial restoring divider
// of DATA_WIDTH+FRAC_BITS steps. Items wait in the two-entry queue, which
// lets the front accept while the back end works.
module loss_value_and_gradient import lvg_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  lvg_in_if.sink in_ch,
  lvg_out_if.source out_ch,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  logic [1:0] loss_mode;
  logic q_valid, q_ready, q_last;
  logic signed [DATA_WIDTH-1:0] q_p, q_t;
  logic [1:0] q_mode;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_LOSS_MODE) ? {30'd0, loss_mode} : 32'd0;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) loss_mode <= MODE_MSE;
    else if (psel && penable && pwrite && paddr == ADDR_LOSS_MODE) loss_mode <= pwdata[1:0];
  end

  lvg_front #(.DW(DATA_WIDTH)) u_front (
    .clk, .rst, .in_ch, .mode(loss_mode), .q_valid, .q_ready,
    .q_p, .q_t, .q_last, .q_mode
  );

  lvg_back #(.DW(DATA_WIDTH), .FB(FRAC_BITS)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_p, .q_t, .q_last, .q_mode, .out_ch
  );
endmodule
